// File: rtl/lbs_pkg.sv
// Shared types and constants of the linear blend skinning core.
package lbs_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_WORLD  = 2'd0,
        OP_INV    = 2'd1,
        OP_WEIGHT = 2'd2
    } op_t;

    // Where a result of the shared multiply-accumulate unit goes.
    typedef enum logic [1:0] {
        DEST_T = 2'd0,
        DEST_R = 2'd1,
        DEST_A = 2'd2
    } dest_t;

    typedef struct packed {
        dest_t      dest;
        logic [1:0] row;
    } mac_tag_t;

    typedef struct packed {
        logic     first;
        logic     last;
        logic     wgt_shift;
        mac_tag_t tag;
    } mac_ctl_t;

    localparam int VAL_W       = 32;
    localparam int WEIGHT_W    = 17;
    localparam int WEIGHT_BITS = 16;
    localparam int WPROD_W     = 34;
    localparam int ACC_W       = 48;
    localparam int WSUM_W      = 23;
    localparam int S_DATA_W    = 160;
    localparam int M_DATA_W    = 120;

    localparam logic [WSUM_W-1:0] SUM_LOW_OK  = 23'd64881;
    localparam logic [WSUM_W-1:0] SUM_HIGH_OK = 23'd66191;
    localparam logic [WSUM_W-1:0] WSUM_MAX    = 23'h7FFFFF;

endpackage

// File: rtl/lbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// File: rtl/lbs_mac.sv
// Shared multiply, floor-shift and accumulate unit of the skinning core.
module lbs_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [31:0]            a,
    input  logic signed [31:0]            b,
    input  lbs_pkg::mac_ctl_t             ctl,
    output logic                          res_valid,
    output lbs_pkg::mac_tag_t             res_tag,
    output logic signed [65-FRAC_BITS:0]  res
);
    import lbs_pkg::*;

    localparam int ROW_W = 66 - FRAC_BITS;

    logic                    v1_reg;
    mac_ctl_t                ctl1_reg;
    logic signed [63:0]      prod_reg;
    logic signed [63:0]      shifted;
    logic signed [ROW_W-1:0] term;
    logic signed [ROW_W-1:0] acc_reg;
    logic signed [ROW_W-1:0] acc_next;
    logic                    res_valid_reg;
    mac_tag_t                tag_reg;

    // Arithmetic shift of the exact product rounds toward minus infinity.
    assign shifted  = ctl1_reg.wgt_shift ? (prod_reg >>> WEIGHT_BITS)
                                         : (prod_reg >>> FRAC_BITS);
    assign term     = shifted[ROW_W-1:0];
    assign acc_next = (ctl1_reg.first ? '0 : acc_reg) + term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= in_valid;
            res_valid_reg <= v1_reg && ctl1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl1_reg <= ctl;
        prod_reg <= a * b;
        if (v1_reg)
        begin
            acc_reg <= acc_next;
            tag_reg <= ctl1_reg.tag;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_tag   = tag_reg;
    assign res       = acc_reg;

endmodule

// File: rtl/linear_blend_skinning_core.sv
// Linear blend skinning core: matrix stores, sequencer and weighted accumulation.
//
// A matrix element write request is taken and leaves the core ready for the next
// request. A weight request keeps the core busy after it is taken: one shared 32x32
// multiplier works through 16 products of the inverse bind matrix, 12 products of
// the world matrix and 3 weight products in turn, and each matrix phase waits for
// the memory read and the multiply-accumulate pipeline to drain. A weight request
// whose joint lies beyond the stores skips both matrix phases. The result of a
// vertex is held in an output register, so the core takes the next request while
// it waits; a following final weight request waits only if that register is
// still full. Matrix entries that were never written read back as anything.
module linear_blend_skinning_core #(
    parameter int MAX_JOINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // joint_index, matrix_element, matrix_value, bind_x, bind_y, bind_z, blend_weight
    input  logic [lbs_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // skinned_x, skinned_y, skinned_z, weight_total
    output logic [lbs_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // weight_sum_bad
    output logic                           m_axis_tuser
);
    import lbs_pkg::*;

    localparam int AW    = $clog2(MAX_JOINTS * 16);
    localparam int ROW_W = 66 - FRAC_BITS;
    localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INV      = 8'b0000_0010,
        S_INV_WAIT = 8'b0000_0100,
        S_WLD      = 8'b0000_1000,
        S_WLD_WAIT = 8'b0001_0000,
        S_WGT      = 8'b0010_0000,
        S_WGT_WAIT = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [3:0]               cnt_reg;
    logic [3:0]               cnt_next;
    logic [5:0]               joint_reg;
    logic signed [31:0]       bind_reg [3];
    logic [WEIGHT_W-1:0]      w_reg;
    logic                     last_reg;

    logic                     iss_valid_reg;
    dest_t                    iss_dest_reg;
    logic [1:0]               iss_row_reg;
    logic [1:0]               iss_col_reg;

    logic signed [31:0]       t_reg [4];
    logic signed [31:0]       r_reg [3];
    logic signed [ACC_W-1:0]  accum_reg [3];
    logic [WSUM_W-1:0]        accw_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [M_DATA_W-1:0]      out_data_reg;
    logic                     out_bad_reg;

    logic                     accept;
    op_t                      in_op;
    logic                     in_range;
    logic                     issuing;
    logic                     reading;
    logic [AW+9:0]            wr_full;
    logic [AW+9:0]            rd_full;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic [31:0]              inv_q;
    logic [31:0]              wld_q;

    logic signed [31:0]       mac_a;
    logic signed [31:0]       mac_b;
    mac_ctl_t                 mac_ctl;
    logic                     res_valid;
    mac_tag_t                 res_tag;
    logic signed [ROW_W-1:0]  res;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic [WSUM_W:0]          wsum_full;
    logic [WSUM_W-1:0]        wsum_next;
    logic                     fin_emit;

    function automatic logic signed [31:0] row_sat32(input logic signed [ROW_W-1:0] v);
        logic signed [31:0] r;
        if (&v[ROW_W-1:31] || ~|v[ROW_W-1:31])
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[ROW_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] acc_sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31])
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_op         = op_t'(s_axis_tuser);
    assign in_range      = (32'(s_axis_tdata[5:0]) < MAX_JOINTS);

    // Both stores are addressed as joint times sixteen plus element.
    assign wr_full = {{AW{1'b0}}, s_axis_tdata[5:0], s_axis_tdata[9:6]};
    assign wr_addr = wr_full[AW-1:0];
    assign rd_full = {{AW{1'b0}}, joint_reg, cnt_reg};
    assign rd_addr = rd_full[AW-1:0];

    assign issuing = (state_reg == S_INV) || (state_reg == S_WLD) || (state_reg == S_WGT);
    assign reading = (state_reg == S_INV) || (state_reg == S_WLD);

    lbs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_JOINTS * 16)
    ) u_world_ram (
        .clk   (clk),
        .we    (accept && in_op == OP_WORLD && in_range),
        .waddr (wr_addr),
        .wdata (s_axis_tdata[41:10]),
        .re    (reading),
        .raddr (rd_addr),
        .rdata (wld_q)
    );

    lbs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_JOINTS * 16)
    ) u_inv_ram (
        .clk   (clk),
        .we    (accept && in_op == OP_INV && in_range),
        .waddr (wr_addr),
        .wdata (s_axis_tdata[41:10]),
        .re    (reading),
        .raddr (rd_addr),
        .rdata (inv_q)
    );

    // Operand selection for the request issued in the previous cycle.
    always_comb
    begin
        mac_a = '0;
        mac_b = '0;
        case (iss_dest_reg)
            DEST_T:
            begin
                mac_a = $signed(inv_q);
                case (iss_col_reg)
                    2'd0:    mac_b = bind_reg[0];
                    2'd1:    mac_b = bind_reg[1];
                    2'd2:    mac_b = bind_reg[2];
                    default: mac_b = ONE_Q;
                endcase
            end
            DEST_R:
            begin
                mac_a = $signed(wld_q);
                mac_b = t_reg[iss_col_reg];
            end
            DEST_A:
            begin
                case (iss_row_reg)
                    2'd1:    mac_a = r_reg[1];
                    2'd2:    mac_a = r_reg[2];
                    default: mac_a = r_reg[0];
                endcase
                mac_b = $signed({15'd0, w_reg});
            end
            default:
            begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
        mac_ctl.first     = (iss_col_reg == 2'd0);
        mac_ctl.last      = (iss_dest_reg == DEST_A) || (iss_col_reg == 2'd3);
        mac_ctl.wgt_shift = (iss_dest_reg == DEST_A);
        mac_ctl.tag.dest  = iss_dest_reg;
        mac_ctl.tag.row   = iss_row_reg;
    end

    lbs_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iss_valid_reg),
        .a         (mac_a),
        .b         (mac_b),
        .ctl       (mac_ctl),
        .res_valid (res_valid),
        .res_tag   (res_tag),
        .res       (res)
    );

    // Weighted terms fit well inside WPROD_W bits, so only those bits are added.
    assign acc_sum = $signed({accum_reg[res_tag.row][ACC_W-1], accum_reg[res_tag.row]})
                   + (ACC_W + 1)'($signed(res[WPROD_W-1:0]));
    assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                   ? {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}}
                   : acc_sum[ACC_W-1:0];

    assign wsum_full = {1'b0, accw_reg} + {{(WSUM_W + 1 - WEIGHT_W){1'b0}}, w_reg};
    assign wsum_next = wsum_full[WSUM_W] ? WSUM_MAX : wsum_full[WSUM_W-1:0];

    assign fin_emit = (state_reg == S_FIN) && last_reg && (!out_valid_reg || m_axis_tready);
    assign out_valid_next = (out_valid_reg && !m_axis_tready) || fin_emit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_op == OP_WEIGHT)
                begin
                    state_next = in_range ? S_INV : S_WGT;
                end
            end
            S_INV:
            begin
                if (cnt_reg == 4'd15)
                begin
                    state_next = S_INV_WAIT;
                end
            end
            S_INV_WAIT:
            begin
                if (res_valid && res_tag.row == 2'd3)
                begin
                    state_next = S_WLD;
                end
            end
            S_WLD:
            begin
                if (cnt_reg == 4'd11)
                begin
                    state_next = S_WLD_WAIT;
                end
            end
            S_WLD_WAIT:
            begin
                if (res_valid && res_tag.row == 2'd2)
                begin
                    state_next = S_WGT;
                end
            end
            S_WGT:
            begin
                if (cnt_reg == 4'd2)
                begin
                    state_next = S_WGT_WAIT;
                end
            end
            S_WGT_WAIT:
            begin
                if (res_valid && res_tag.row == 2'd2)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!last_reg || fin_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_next != state_reg)
        begin
            cnt_next = '0;
        end
        else if (issuing)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            iss_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            accum_reg[0]  <= '0;
            accum_reg[1]  <= '0;
            accum_reg[2]  <= '0;
            accw_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            iss_valid_reg <= issuing;
            out_valid_reg <= out_valid_next;
            if (res_valid && res_tag.dest == DEST_A)
            begin
                accum_reg[res_tag.row] <= acc_sat;
            end
            if (state_reg == S_FIN)
            begin
                if (fin_emit)
                begin
                    accum_reg[0] <= '0;
                    accum_reg[1] <= '0;
                    accum_reg[2] <= '0;
                    accw_reg     <= '0;
                end
                else if (!last_reg)
                begin
                    accw_reg <= wsum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_op == OP_WEIGHT)
        begin
            joint_reg   <= s_axis_tdata[5:0];
            bind_reg[0] <= $signed(s_axis_tdata[73:42]);
            bind_reg[1] <= $signed(s_axis_tdata[105:74]);
            bind_reg[2] <= $signed(s_axis_tdata[137:106]);
            w_reg       <= s_axis_tdata[154:138];
            last_reg    <= s_axis_tlast;
            // A joint beyond the stores contributes nothing but its weight.
            if (!in_range)
            begin
                r_reg[0] <= '0;
                r_reg[1] <= '0;
                r_reg[2] <= '0;
            end
        end

        iss_dest_reg <= (state_reg == S_WLD) ? DEST_R
                      : (state_reg == S_WGT) ? DEST_A : DEST_T;
        iss_row_reg  <= (state_reg == S_WGT) ? cnt_reg[1:0] : cnt_reg[3:2];
        iss_col_reg  <= (state_reg == S_WGT) ? 2'd0 : cnt_reg[1:0];

        if (res_valid)
        begin
            case (res_tag.dest)
                DEST_T:
                begin
                    t_reg[res_tag.row] <= row_sat32(res);
                end
                DEST_R:
                begin
                    case (res_tag.row)
                        2'd1:    r_reg[1] <= row_sat32(res);
                        2'd2:    r_reg[2] <= row_sat32(res);
                        default: r_reg[0] <= row_sat32(res);
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        if (fin_emit)
        begin
            out_data_reg <= {1'b0, wsum_next, acc_sat32(accum_reg[2]),
                             acc_sat32(accum_reg[1]), acc_sat32(accum_reg[0])};
            out_bad_reg  <= (wsum_next != '0)
                         && ((wsum_next < SUM_LOW_OK) || (wsum_next > SUM_HIGH_OK));
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_bad_reg;

endmodule

// File: rtl/lbs_checker.sv
// Port-level assertions for the skinning core and their bind to the top level.
module lbs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [lbs_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic [1:0]                   s_axis_tuser,
    input logic                         s_axis_tlast,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lbs_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tuser
);
    import lbs_pkg::*;

    logic weight_req;
    logic other_req;

    assign weight_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WEIGHT);
    assign other_req  = s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_WEIGHT);

    // A weight request makes the core drop its ready flag right after it is taken.
    a_weight_busy: assert property (@(posedge clk) disable iff (!rst_n)
        weight_req |=> !s_axis_tready)
        else $error("core ready right after a weight request");

    // Matrix writes and unused requests leave the core ready right after they are taken.
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        other_req |=> s_axis_tready)
        else $error("core not ready after a matrix write");

    // The range flag agrees with the reported weight total.
    a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser ==
            ((m_axis_tdata[118:96] != '0) &&
             ((m_axis_tdata[118:96] < SUM_LOW_OK) || (m_axis_tdata[118:96] > SUM_HIGH_OK)))))
        else $error("weight range flag does not match weight total");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                               && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind linear_blend_skinning_core lbs_checker u_lbs_checker (.*);
